// File: sv/absem_pkg.sv
// ============================================================================
// absem_pkg: shared definitions for the signal error metrics block
// Widths, limits, operand selection codes and the control types that pass
// between the sequencer and the shared arithmetic unit.
// ============================================================================
package absem_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAG_BITS        = 16;
    localparam int SQUARE_BITS     = 2 * MAG_BITS;
    localparam int REF_ENERGY_BITS = 51;
    localparam int RES_ENERGY_BITS = 52;
    localparam int ABS_SUM_BITS    = 36;
    localparam int COUNT_BITS      = 21;
    localparam int DIVIDEND_BITS   = 52;
    localparam int QUOT_BITS       = 32;
    localparam int ROOT_BITS       = 16;
    localparam int REM_BITS        = 22;
    localparam int STEP_BITS       = 6;
    localparam int DIV_STEPS       = DIVIDEND_BITS;
    localparam int SQRT_STEPS      = QUOT_BITS / 2;

    localparam logic [COUNT_BITS-1:0] MAX_SAMPLES = COUNT_BITS'(1048576);

    localparam logic [1:0] SEL_REF = 2'd0;
    localparam logic [1:0] SEL_CAP = 2'd1;
    localparam logic [1:0] SEL_RES = 2'd2;
    localparam logic [1:0] SEL_ABS = 2'd3;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_sts_t;

endpackage

// File: sv/absem_if.sv
// ============================================================================
// absem_if: stream interfaces of the signal error metrics block
// One interface for the incoming sample pairs and one for the span results,
// each with valid, ready and the payload of one beat.
// ============================================================================
interface absem_in_if;
    import absem_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_BITS-1:0] ref_sample;
    logic signed [SAMPLE_BITS-1:0] cap_sample;
    logic                         last_sample;

    modport source (output valid, output ref_sample, output cap_sample,
                    output last_sample, input ready);
    modport sink   (input valid, input ref_sample, input cap_sample,
                    input last_sample, output ready);
endinterface

interface absem_out_if;
    import absem_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MAG_BITS-1:0]   peak_ref;
    logic [MAG_BITS-1:0]   peak_cap;
    logic [MAG_BITS-1:0]   peak_residual;
    logic [ROOT_BITS-1:0]  rms_ref;
    logic [ROOT_BITS-1:0]  rms_cap;
    logic [ROOT_BITS-1:0]  rms_residual;
    logic [MAG_BITS-1:0]   mean_abs_error;
    logic [COUNT_BITS-1:0] sample_count;
    logic                  truncated;

    modport source (output valid, output peak_ref, output peak_cap,
                    output peak_residual, output rms_ref, output rms_cap,
                    output rms_residual, output mean_abs_error,
                    output sample_count, output truncated, input ready);
    modport sink   (input valid, input peak_ref, input peak_cap,
                    input peak_residual, input rms_ref, input rms_cap,
                    input rms_residual, input mean_abs_error,
                    input sample_count, input truncated, output ready);
endinterface

// File: sv/absem_arith.sv
// ============================================================================
// absem_arith: shared divide and square root unit
// Restoring division of a 52-bit dividend by the sample count, one quotient
// bit a cycle, and digit-by-digit integer square root of a 32-bit value, one
// root bit a cycle, both on the same subtractor and remainder register.
// ============================================================================
module absem_arith (
    input  logic                                clk,
    input  logic                                rst_n,
    input  absem_pkg::arith_ctl_t               ctl,
    input  logic [absem_pkg::DIVIDEND_BITS-1:0] dividend,
    input  logic [absem_pkg::COUNT_BITS-1:0]    divisor,
    input  logic [absem_pkg::QUOT_BITS-1:0]     radicand,
    output absem_pkg::arith_sts_t               sts,
    output logic [absem_pkg::DIVIDEND_BITS-1:0] quotient,
    output logic [absem_pkg::ROOT_BITS-1:0]     root
);
    import absem_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    arith_op_t                op_reg, op_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [DIVIDEND_BITS-1:0] dq_reg, dq_next;
    logic [REM_BITS-1:0]      rem_reg, rem_next;
    logic [ROOT_BITS-1:0]     root_reg, root_next;

    logic [REM_BITS-1:0]      sub_a;
    logic [REM_BITS-1:0]      sub_b;
    logic [REM_BITS:0]        diff;
    logic                     fits;
    logic                     last_step;

    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            sub_a = {rem_reg[REM_BITS-2:0], dq_reg[DIVIDEND_BITS-1]};
            sub_b = {1'b0, divisor};
        end
        else
        begin
            sub_a = {rem_reg[REM_BITS-3:0], dq_reg[DIVIDEND_BITS-1 -: 2]};
            sub_b = {{(REM_BITS-ROOT_BITS-2){1'b0}}, root_reg, 2'b01};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        fits = ~diff[REM_BITS];
        if (op_reg == OP_DIV)
        begin
            last_step = (step_reg == STEP_BITS'(DIV_STEPS - 1));
        end
        else
        begin
            last_step = (step_reg == STEP_BITS'(SQRT_STEPS - 1));
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        step_next = step_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            step_next = '0;
            rem_next  = '0;
            root_next = '0;
            if (ctl.op == OP_DIV)
            begin
                dq_next = dividend;
            end
            else
            begin
                dq_next = {radicand, {(DIVIDEND_BITS-QUOT_BITS){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[REM_BITS-1:0] : sub_a;
            step_next = step_reg + 1'b1;
            if (op_reg == OP_DIV)
            begin
                dq_next = {dq_reg[DIVIDEND_BITS-2:0], fits};
            end
            else
            begin
                dq_next   = {dq_reg[DIVIDEND_BITS-3:0], 2'b00};
                root_next = {root_reg[ROOT_BITS-2:0], fits};
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = dq_reg;
    assign root     = root_reg;

endmodule

// File: sv/ab_signal_error_metrics_core.sv
// ============================================================================
// ab_signal_error_metrics_core: peak, RMS and mean absolute error of a span
// Folds paired reference and capture samples into peak, energy and absolute
// error accumulators and, at the end of a span, reports peaks, RMS values,
// mean absolute error, the pair count and the truncation flag.
// ============================================================================
//
//  Port      Modport  Beat contents
//  --------  -------  --------------------------------------------------------
//  samples   sink     ref_sample, cap_sample (Q1.15), last_sample
//  metrics   source   peaks, RMS values, mean abs error, sample_count, truncated
//
// A sample pair occupies the block from its beat through three passes through
// the single 16 x 16 squaring multiplier; no new beat is taken meanwhile.
// At the end of a span the shared divide and root unit runs four 52-bit
// divisions and then three 16-bit roots, and the result is loaded into the
// output register once that register is free.
// The result sits in an output register, so the next span may start while it
// waits; a stalled result only holds the block once the next span ends.
// Reset clears all accumulators and the sequencer.
//
module ab_signal_error_metrics_core (
    input logic        clk,
    input logic        rst_n,
    absem_in_if.sink   samples,
    absem_out_if.source metrics
);
    import absem_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_ROOT   = 5'b01000,
        ST_LOAD   = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 sel_reg, sel_next;
    logic                       launch_reg, launch_next;
    logic                       span_end_reg, span_end_next;
    logic                       trunc_reg, trunc_next;

    logic [MAG_BITS-1:0]        mag_ref_reg, mag_ref_next;
    logic [MAG_BITS-1:0]        mag_cap_reg, mag_cap_next;
    logic [MAG_BITS-1:0]        mag_res_reg, mag_res_next;

    logic [MAG_BITS-1:0]        peak_ref_reg, peak_ref_next;
    logic [MAG_BITS-1:0]        peak_cap_reg, peak_cap_next;
    logic [MAG_BITS-1:0]        peak_res_reg, peak_res_next;
    logic [REF_ENERGY_BITS-1:0] energy_ref_reg, energy_ref_next;
    logic [REF_ENERGY_BITS-1:0] energy_cap_reg, energy_cap_next;
    logic [RES_ENERGY_BITS-1:0] energy_res_reg, energy_res_next;
    logic [ABS_SUM_BITS-1:0]    abs_sum_reg, abs_sum_next;
    logic [COUNT_BITS-1:0]      pair_count_reg, pair_count_next;

    logic [QUOT_BITS-1:0]       mean_ref_reg, mean_ref_next;
    logic [QUOT_BITS-1:0]       mean_cap_reg, mean_cap_next;
    logic [QUOT_BITS-1:0]       mean_res_reg, mean_res_next;
    logic [MAG_BITS-1:0]        mae_reg, mae_next;
    logic [ROOT_BITS-1:0]       rms_ref_reg, rms_ref_next;
    logic [ROOT_BITS-1:0]       rms_cap_reg, rms_cap_next;
    logic [ROOT_BITS-1:0]       rms_res_reg, rms_res_next;

    logic                       out_valid_reg, out_valid_next;
    logic [MAG_BITS-1:0]        out_peak_ref_reg, out_peak_ref_next;
    logic [MAG_BITS-1:0]        out_peak_cap_reg, out_peak_cap_next;
    logic [MAG_BITS-1:0]        out_peak_res_reg, out_peak_res_next;
    logic [ROOT_BITS-1:0]       out_rms_ref_reg, out_rms_ref_next;
    logic [ROOT_BITS-1:0]       out_rms_cap_reg, out_rms_cap_next;
    logic [ROOT_BITS-1:0]       out_rms_res_reg, out_rms_res_next;
    logic [MAG_BITS-1:0]        out_mae_reg, out_mae_next;
    logic [COUNT_BITS-1:0]      out_count_reg, out_count_next;
    logic                       out_trunc_reg, out_trunc_next;

    logic                       accept;
    logic                       load_fire;
    logic [SAMPLE_BITS:0]       ref_ext;
    logic [SAMPLE_BITS:0]       cap_ext;
    logic [SAMPLE_BITS:0]       diff_ext;
    logic [SAMPLE_BITS:0]       ref_abs;
    logic [SAMPLE_BITS:0]       cap_abs;
    logic [SAMPLE_BITS:0]       diff_abs;
    logic [COUNT_BITS-1:0]      count_inc;
    logic                       at_limit;
    logic [MAG_BITS-1:0]        mul_in;
    logic [SQUARE_BITS-1:0]     square;

    arith_ctl_t                 arith_ctl;
    arith_sts_t                 arith_sts;
    logic [DIVIDEND_BITS-1:0]   arith_dividend;
    logic [QUOT_BITS-1:0]       arith_radicand;
    logic [DIVIDEND_BITS-1:0]   arith_quotient;
    logic [ROOT_BITS-1:0]       arith_root;

    absem_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (arith_ctl),
        .dividend (arith_dividend),
        .divisor  (pair_count_reg),
        .radicand (arith_radicand),
        .sts      (arith_sts),
        .quotient (arith_quotient),
        .root     (arith_root)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign load_fire     = (state_reg == ST_LOAD) && (!out_valid_reg || metrics.ready);

    always_comb
    begin
        ref_ext   = {samples.ref_sample[SAMPLE_BITS-1], samples.ref_sample};
        cap_ext   = {samples.cap_sample[SAMPLE_BITS-1], samples.cap_sample};
        diff_ext  = ref_ext - cap_ext;
        ref_abs   = ref_ext[SAMPLE_BITS] ? (~ref_ext + 1'b1) : ref_ext;
        cap_abs   = cap_ext[SAMPLE_BITS] ? (~cap_ext + 1'b1) : cap_ext;
        diff_abs  = diff_ext[SAMPLE_BITS] ? (~diff_ext + 1'b1) : diff_ext;
        count_inc = pair_count_reg + 1'b1;
        at_limit  = (count_inc >= MAX_SAMPLES);
    end

    always_comb
    begin
        case (sel_reg)
            SEL_REF: mul_in = mag_ref_reg;
            SEL_CAP: mul_in = mag_cap_reg;
            default: mul_in = mag_res_reg;
        endcase
        square = mul_in * mul_in;

        case (sel_reg)
            SEL_REF:
            begin
                arith_dividend = DIVIDEND_BITS'(energy_ref_reg);
                arith_radicand = mean_ref_reg;
            end
            SEL_CAP:
            begin
                arith_dividend = DIVIDEND_BITS'(energy_cap_reg);
                arith_radicand = mean_cap_reg;
            end
            SEL_RES:
            begin
                arith_dividend = DIVIDEND_BITS'(energy_res_reg);
                arith_radicand = mean_res_reg;
            end
            default:
            begin
                arith_dividend = DIVIDEND_BITS'(abs_sum_reg);
                arith_radicand = mean_res_reg;
            end
        endcase

        arith_ctl.start = launch_reg;
        arith_ctl.op    = (state_reg == ST_ROOT) ? OP_SQRT : OP_DIV;
    end

    always_comb
    begin
        state_next        = state_reg;
        sel_next          = sel_reg;
        launch_next       = 1'b0;
        span_end_next     = span_end_reg;
        trunc_next        = trunc_reg;
        mag_ref_next      = mag_ref_reg;
        mag_cap_next      = mag_cap_reg;
        mag_res_next      = mag_res_reg;
        peak_ref_next     = peak_ref_reg;
        peak_cap_next     = peak_cap_reg;
        peak_res_next     = peak_res_reg;
        energy_ref_next   = energy_ref_reg;
        energy_cap_next   = energy_cap_reg;
        energy_res_next   = energy_res_reg;
        abs_sum_next      = abs_sum_reg;
        pair_count_next   = pair_count_reg;
        mean_ref_next     = mean_ref_reg;
        mean_cap_next     = mean_cap_reg;
        mean_res_next     = mean_res_reg;
        mae_next          = mae_reg;
        rms_ref_next      = rms_ref_reg;
        rms_cap_next      = rms_cap_reg;
        rms_res_next      = rms_res_reg;
        out_valid_next    = out_valid_reg;
        out_peak_ref_next = out_peak_ref_reg;
        out_peak_cap_next = out_peak_cap_reg;
        out_peak_res_next = out_peak_res_reg;
        out_rms_ref_next  = out_rms_ref_reg;
        out_rms_cap_next  = out_rms_cap_reg;
        out_rms_res_next  = out_rms_res_reg;
        out_mae_next      = out_mae_reg;
        out_count_next    = out_count_reg;
        out_trunc_next    = out_trunc_reg;

        if (out_valid_reg && metrics.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_ref_next    = ref_abs[MAG_BITS-1:0];
                    mag_cap_next    = cap_abs[MAG_BITS-1:0];
                    mag_res_next    = diff_abs[MAG_BITS-1:0];
                    if (ref_abs[MAG_BITS-1:0] > peak_ref_reg)
                    begin
                        peak_ref_next = ref_abs[MAG_BITS-1:0];
                    end
                    if (cap_abs[MAG_BITS-1:0] > peak_cap_reg)
                    begin
                        peak_cap_next = cap_abs[MAG_BITS-1:0];
                    end
                    if (diff_abs[MAG_BITS-1:0] > peak_res_reg)
                    begin
                        peak_res_next = diff_abs[MAG_BITS-1:0];
                    end
                    abs_sum_next    = abs_sum_reg + ABS_SUM_BITS'(diff_abs[MAG_BITS-1:0]);
                    pair_count_next = count_inc;
                    span_end_next   = samples.last_sample || at_limit;
                    trunc_next      = !samples.last_sample && at_limit;
                    sel_next        = SEL_REF;
                    state_next      = ST_SQUARE;
                end
            end

            ST_SQUARE:
            begin
                case (sel_reg)
                    SEL_REF: energy_ref_next = energy_ref_reg + REF_ENERGY_BITS'(square);
                    SEL_CAP: energy_cap_next = energy_cap_reg + REF_ENERGY_BITS'(square);
                    default: energy_res_next = energy_res_reg + RES_ENERGY_BITS'(square);
                endcase
                if (sel_reg == SEL_RES)
                begin
                    sel_next = SEL_REF;
                    if (span_end_reg)
                    begin
                        state_next  = ST_DIVIDE;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end

            ST_DIVIDE:
            begin
                if (arith_sts.done)
                begin
                    case (sel_reg)
                        SEL_REF: mean_ref_next = arith_quotient[QUOT_BITS-1:0];
                        SEL_CAP: mean_cap_next = arith_quotient[QUOT_BITS-1:0];
                        SEL_RES: mean_res_next = arith_quotient[QUOT_BITS-1:0];
                        default: mae_next      = arith_quotient[MAG_BITS-1:0];
                    endcase
                    launch_next = 1'b1;
                    if (sel_reg == SEL_ABS)
                    begin
                        sel_next   = SEL_REF;
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        sel_next = sel_reg + 1'b1;
                    end
                end
            end

            ST_ROOT:
            begin
                if (arith_sts.done)
                begin
                    case (sel_reg)
                        SEL_REF: rms_ref_next = arith_root;
                        SEL_CAP: rms_cap_next = arith_root;
                        default: rms_res_next = arith_root;
                    endcase
                    if (sel_reg == SEL_RES)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        sel_next    = sel_reg + 1'b1;
                        launch_next = 1'b1;
                    end
                end
            end

            ST_LOAD:
            begin
                if (load_fire)
                begin
                    out_valid_next    = 1'b1;
                    out_peak_ref_next = peak_ref_reg;
                    out_peak_cap_next = peak_cap_reg;
                    out_peak_res_next = peak_res_reg;
                    out_rms_ref_next  = rms_ref_reg;
                    out_rms_cap_next  = rms_cap_reg;
                    out_rms_res_next  = rms_res_reg;
                    out_mae_next      = mae_reg;
                    out_count_next    = pair_count_reg;
                    out_trunc_next    = trunc_reg;
                    peak_ref_next     = '0;
                    peak_cap_next     = '0;
                    peak_res_next     = '0;
                    energy_ref_next   = '0;
                    energy_cap_next   = '0;
                    energy_res_next   = '0;
                    abs_sum_next      = '0;
                    pair_count_next   = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sel_reg        <= SEL_REF;
            launch_reg     <= 1'b0;
            span_end_reg   <= 1'b0;
            trunc_reg      <= 1'b0;
            peak_ref_reg   <= '0;
            peak_cap_reg   <= '0;
            peak_res_reg   <= '0;
            energy_ref_reg <= '0;
            energy_cap_reg <= '0;
            energy_res_reg <= '0;
            abs_sum_reg    <= '0;
            pair_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            launch_reg     <= launch_next;
            span_end_reg   <= span_end_next;
            trunc_reg      <= trunc_next;
            peak_ref_reg   <= peak_ref_next;
            peak_cap_reg   <= peak_cap_next;
            peak_res_reg   <= peak_res_next;
            energy_ref_reg <= energy_ref_next;
            energy_cap_reg <= energy_cap_next;
            energy_res_reg <= energy_res_next;
            abs_sum_reg    <= abs_sum_next;
            pair_count_reg <= pair_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_ref_reg      <= mag_ref_next;
        mag_cap_reg      <= mag_cap_next;
        mag_res_reg      <= mag_res_next;
        mean_ref_reg     <= mean_ref_next;
        mean_cap_reg     <= mean_cap_next;
        mean_res_reg     <= mean_res_next;
        mae_reg          <= mae_next;
        rms_ref_reg      <= rms_ref_next;
        rms_cap_reg      <= rms_cap_next;
        rms_res_reg      <= rms_res_next;
        out_peak_ref_reg <= out_peak_ref_next;
        out_peak_cap_reg <= out_peak_cap_next;
        out_peak_res_reg <= out_peak_res_next;
        out_rms_ref_reg  <= out_rms_ref_next;
        out_rms_cap_reg  <= out_rms_cap_next;
        out_rms_res_reg  <= out_rms_res_next;
        out_mae_reg      <= out_mae_next;
        out_count_reg    <= out_count_next;
        out_trunc_reg    <= out_trunc_next;
    end

    assign metrics.valid          = out_valid_reg;
    assign metrics.peak_ref       = out_peak_ref_reg;
    assign metrics.peak_cap       = out_peak_cap_reg;
    assign metrics.peak_residual  = out_peak_res_reg;
    assign metrics.rms_ref        = out_rms_ref_reg;
    assign metrics.rms_cap        = out_rms_cap_reg;
    assign metrics.rms_residual   = out_rms_res_reg;
    assign metrics.mean_abs_error = out_mae_reg;
    assign metrics.sample_count   = out_count_reg;
    assign metrics.truncated      = out_trunc_reg;

    // An RMS value or the mean absolute error can never exceed the peak of the same span.
    a_rms_within_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rms_ref_reg <= out_peak_ref_reg)
                       && (out_rms_cap_reg <= out_peak_cap_reg)
                       && (out_rms_res_reg <= out_peak_res_reg)
                       && (out_mae_reg <= out_peak_res_reg))
        else $error("span result exceeds its peak");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= MAX_SAMPLES)
        else $error("pair count beyond limit");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (pair_count_reg != '0))
        else $error("division started with an empty span");

    a_launch_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> !arith_sts.busy
                    && ((state_reg == ST_DIVIDE) || (state_reg == ST_ROOT)))
        else $error("arithmetic unit launched while busy or out of sequence");

    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> (pair_count_reg == '0) && (abs_sum_reg == '0)
                   && (energy_res_reg == '0) && out_valid_reg)
        else $error("accumulators not cleared after result load");

endmodule
